[rtl/ccs_pkg.sv]
// Shared types and constants for the C comment stripper.
// Used by every module of the block; depends on nothing else.
package ccs_pkg;

  // Lexer states of the comment scanner.
  typedef enum logic [2:0] {
    ST_CODE     = 3'd0,
    ST_SLASH    = 3'd1,
    ST_STAR     = 3'd2,
    ST_COMMENT  = 3'd3,
    ST_CHR      = 3'd4,
    ST_STR      = 3'd5,
    ST_STR_ESC  = 3'd6,
    ST_CHR_ESC  = 3'd7
  } lex_state_t;

  // Input request and result word kinds.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_END  = 1'b1;
  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Characters the lexer looks for.
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // One queue entry: an optional leading text byte, then the main result.
  typedef struct packed {
    logic        has_pre;
    logic [7:0]  pre_byte;
    logic        main_kind;
    logic [7:0]  main_byte;
    logic        unterminated;
    logic [31:0] error_line;
  } ccs_entry_t;

  // State entered from plain code on a given byte.
  function automatic lex_state_t code_next(input logic [7:0] c);
    lex_state_t s;
    if (c == CH_SLASH) begin
      s = ST_SLASH;
    end else if (c == CH_SQUOTE) begin
      s = ST_CHR;
    end else if (c == CH_DQUOTE) begin
      s = ST_STR;
    end else begin
      s = ST_CODE;
    end
    return s;
  endfunction

endpackage

[rtl/c_comment_stripper_top.sv]
// C comment stripper: one input word per cycle, sustained while the queue is
// not full, when each word yields at most one result; a word with two results
// leaves as two output words, absorbed by the entry queue. A result is written
// to the entry queue when its word is accepted, then loaded into the output
// register. Rate is set by the output register draining one word per cycle
// unless out_stall holds it. Synchronous active-low reset returns the lexer to
// code state, the line count to one, and empties the queue and output register.
module c_comment_stripper_top #(
  parameter int LINE_BITS   = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_unterminated,
  output logic [31:0] out_error_line,
  output logic        out_last
);

  ccs_pkg::ccs_entry_t wr_entry;
  ccs_pkg::ccs_entry_t head;
  logic q_push, q_pop, q_full, q_empty, in_accept;

  assign in_stall = q_full;

  // Lexer and classification.
  ccs_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .req_type (in_req_type),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .accept   (in_accept),
    .push     (q_push),
    .entry    (wr_entry)
  );

  // Decoupling queue.
  ccs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Result serializer.
  ccs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (q_pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_unterminated (out_unterminated),
    .out_error_line   (out_error_line),
    .out_last         (out_last)
  );

`ifndef SYNTHESIS
  // An entry is only pushed for a word that was actually accepted.
  a_push_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> in_accept && !q_full)
    else $error("queue push without an accepted word");

  // A status word always closes the results of its input word.
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> out_last)
    else $error("status word not marked last");

  // Text words carry no status information.
  a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_kind |-> !out_unterminated && out_error_line == 32'd0)
    else $error("text word with status fields set");

  // The second word of a pair follows right after the first is taken.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && !out_stall |=> out_valid && out_last)
    else $error("second word of a pair missing");
`endif

endmodule

[rtl/ccs_front.sv]
// Front end of the comment stripper: lexer state, line counters, and
// translation of each accepted word into at most one queue entry. Uses ccs_pkg.
module ccs_front #(
  parameter int LINE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                req_type,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                accept,
  output logic                push,
  output ccs_pkg::ccs_entry_t entry
);

  localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

  ccs_pkg::lex_state_t  state_r, state_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  logic [LINE_BITS-1:0] cn_r, cn_nxt;

  logic [LINE_BITS:0]   close_sum;
  logic [LINE_BITS-1:0] close_line;
  logic [LINE_BITS-1:0] line_inc;
  logic [LINE_BITS-1:0] cn_inc;
  logic [31:0]          line_clip;
  logic                 case_emit;
  logic [7:0]           case_byte;
  logic                 emit_c;
  logic                 is_nl;

  assign accept = in_valid && !q_full;
  assign is_nl  = (in_byte == ccs_pkg::CH_NL);

  // Saturating line arithmetic.
  assign close_sum  = {1'b0, line_r} + {1'b0, cn_r};
  assign close_line = close_sum[LINE_BITS] ? '1 : close_sum[LINE_BITS-1:0];
  assign line_inc   = (&line_r) ? line_r : line_r + LINE_ONE;
  assign cn_inc     = (&cn_r) ? cn_r : cn_r + LINE_ONE;

  // Reported line is clipped to the 32-bit status field.
  generate
    if (LINE_BITS > 32) begin : g_clip_wide
      assign line_clip = (|line_r[LINE_BITS-1:32]) ? 32'hFFFF_FFFF : line_r[31:0];
    end else if (LINE_BITS == 32) begin : g_clip_same
      assign line_clip = line_r;
    end else begin : g_clip_narrow
      assign line_clip = {{(32-LINE_BITS){1'b0}}, line_r};
    end
  endgenerate

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ccs_pkg::ST_CODE;
      line_r  <= LINE_ONE;
      cn_r    <= '0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      cn_r    <= cn_nxt;
    end
  end

  // Lexer next state and entry assembly.
  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    cn_nxt    = cn_r;
    case_emit = 1'b0;
    case_byte = in_byte;
    emit_c    = 1'b0;
    push      = 1'b0;
    entry     = '0;
    if (accept) begin
      if (req_type == ccs_pkg::REQ_END) begin
        // Flush a held character, report status, and return to reset.
        if (state_r == ccs_pkg::ST_SLASH) begin
          entry.has_pre  = 1'b1;
          entry.pre_byte = ccs_pkg::CH_SLASH;
        end else if (state_r == ccs_pkg::ST_STR_ESC || state_r == ccs_pkg::ST_CHR_ESC) begin
          entry.has_pre  = 1'b1;
          entry.pre_byte = ccs_pkg::CH_BSLASH;
        end
        entry.main_kind = ccs_pkg::KIND_STATUS;
        if (state_r == ccs_pkg::ST_COMMENT || state_r == ccs_pkg::ST_STAR) begin
          entry.unterminated = 1'b1;
          entry.error_line   = line_clip;
        end
        push      = 1'b1;
        state_nxt = ccs_pkg::ST_CODE;
        line_nxt  = LINE_ONE;
        cn_nxt    = '0;
      end else begin
        unique case (state_r)
          ccs_pkg::ST_CODE: begin
            state_nxt = ccs_pkg::code_next(in_byte);
          end
          ccs_pkg::ST_SLASH: begin
            case_emit = 1'b1;
            if (in_byte == ccs_pkg::CH_STAR) begin
              case_byte = ccs_pkg::CH_SPACE;
              state_nxt = ccs_pkg::ST_COMMENT;
            end else begin
              case_byte = ccs_pkg::CH_SLASH;
              state_nxt = ccs_pkg::code_next(in_byte);
            end
          end
          ccs_pkg::ST_STAR: begin
            case_emit = is_nl;
            if (in_byte == ccs_pkg::CH_STAR) begin
              state_nxt = ccs_pkg::ST_STAR;
            end else if (in_byte == ccs_pkg::CH_SLASH) begin
              // Comment closes: fold its newlines into the line count.
              line_nxt  = close_line;
              cn_nxt    = '0;
              state_nxt = ccs_pkg::ST_CODE;
            end else begin
              state_nxt = ccs_pkg::ST_COMMENT;
            end
          end
          ccs_pkg::ST_COMMENT: begin
            case_emit = is_nl;
            state_nxt = (in_byte == ccs_pkg::CH_STAR) ? ccs_pkg::ST_STAR
                                                       : ccs_pkg::ST_COMMENT;
          end
          ccs_pkg::ST_CHR: begin
            if (in_byte == ccs_pkg::CH_BSLASH) begin
              state_nxt = ccs_pkg::ST_CHR_ESC;
            end else if (in_byte == ccs_pkg::CH_SQUOTE) begin
              state_nxt = ccs_pkg::ST_CODE;
            end else begin
              state_nxt = ccs_pkg::ST_CHR;
            end
          end
          ccs_pkg::ST_STR: begin
            if (in_byte == ccs_pkg::CH_BSLASH) begin
              state_nxt = ccs_pkg::ST_STR_ESC;
            end else if (in_byte == ccs_pkg::CH_DQUOTE) begin
              state_nxt = ccs_pkg::ST_CODE;
            end else begin
              state_nxt = ccs_pkg::ST_STR;
            end
          end
          ccs_pkg::ST_CHR_ESC: begin
            case_emit = 1'b1;
            case_byte = ccs_pkg::CH_BSLASH;
            state_nxt = ccs_pkg::ST_CHR;
          end
          ccs_pkg::ST_STR_ESC: begin
            case_emit = 1'b1;
            case_byte = ccs_pkg::CH_BSLASH;
            state_nxt = ccs_pkg::ST_STR;
          end
        endcase

        // Newlines count toward the line or, inside a comment, apart.
        if (is_nl) begin
          if (state_nxt != ccs_pkg::ST_COMMENT) begin
            line_nxt = line_inc;
          end else begin
            cn_nxt = cn_inc;
          end
        end

        // The byte itself passes through in code and literals.
        emit_c = (state_nxt == ccs_pkg::ST_CODE || state_nxt == ccs_pkg::ST_STR ||
                  state_nxt == ccs_pkg::ST_CHR) && (state_r != ccs_pkg::ST_STAR);

        entry.main_kind = ccs_pkg::KIND_TEXT;
        if (case_emit && emit_c) begin
          entry.has_pre   = 1'b1;
          entry.pre_byte  = case_byte;
          entry.main_byte = in_byte;
        end else if (case_emit) begin
          entry.main_byte = case_byte;
        end else begin
          entry.main_byte = in_byte;
        end
        push = case_emit || emit_c;
      end
    end
  end

endmodule

[rtl/ccs_queue.sv]
// Small flip-flop queue of result entries between lexer and output stage.
// Uses ccs_pkg for the entry type.
module ccs_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ccs_pkg::ccs_entry_t wr_entry,
  input  logic                pop,
  output ccs_pkg::ccs_entry_t head,
  output logic                full,
  output logic                empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [PW-1:0] PTR_ONE  = PW'(1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  ccs_pkg::ccs_entry_t entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries_r[rd_ptr_r];

  // Entry storage; no reset needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wr_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_ONE;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_ONE;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_ONE;
      end
    end
  end

endmodule

[rtl/ccs_back.sv]
// Output stage: unpacks queue entries into one or two result words and
// holds them in an output register. Uses ccs_pkg for the entry type.
module ccs_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ccs_pkg::ccs_entry_t head,
  input  logic                q_empty,
  output logic                pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic                out_kind,
  output logic [7:0]          out_byte,
  output logic                out_unterminated,
  output logic [31:0]         out_error_line,
  output logic                out_last
);

  logic        valid_r;
  logic        pre_done_r;
  logic        kind_r;
  logic [7:0]  byte_r;
  logic        unt_r;
  logic [31:0] line_r;
  logic        last_r;
  logic        load;
  logic        send_pre;

  assign load     = !valid_r || !out_stall;
  assign send_pre = head.has_pre && !pre_done_r;
  assign pop      = load && !q_empty && !send_pre;

  // Valid flag and phase within the current entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      pre_done_r <= 1'b0;
    end else if (load) begin
      valid_r <= !q_empty;
      if (!q_empty) begin
        pre_done_r <= send_pre;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      if (send_pre) begin
        kind_r <= ccs_pkg::KIND_TEXT;
        byte_r <= head.pre_byte;
        unt_r  <= 1'b0;
        line_r <= '0;
        last_r <= 1'b0;
      end else begin
        kind_r <= head.main_kind;
        byte_r <= head.main_byte;
        unt_r  <= head.unterminated;
        line_r <= head.error_line;
        last_r <= 1'b1;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_byte         = byte_r;
  assign out_unterminated = unt_r;
  assign out_error_line   = line_r;
  assign out_last         = last_r;

endmodule
